@@ src/hps_pkg.sv @@
// ----------------------------------------------------------------------------
// hps_pkg
// Shared widths, register indexes, reset values and types for the heat pump
// sequencer.
// ----------------------------------------------------------------------------
package hps_pkg;

    localparam int TempW   = 12;
    localparam int HysW    = 10;
    localparam int TimeW   = 32;
    localparam int ThrW    = TempW + 1;
    localparam int CfgIdxW = 4;
    localparam int CfgDatW = 32;

    // Register indexes on the configuration port
    localparam logic [CfgIdxW-1:0] REG_WATER_TARGET      = 4'd0;
    localparam logic [CfgIdxW-1:0] REG_HYSTERESIS        = 4'd1;
    localparam logic [CfgIdxW-1:0] REG_SUMP_HEATER_TEMP  = 4'd2;
    localparam logic [CfgIdxW-1:0] REG_RUN_TIMEOUT_MS    = 4'd3;
    localparam logic [CfgIdxW-1:0] REG_DEFROST_START     = 4'd4;
    localparam logic [CfgIdxW-1:0] REG_FAN_TARGET        = 4'd5;
    localparam logic [CfgIdxW-1:0] REG_HEATED_MARK       = 4'd6;
    localparam logic [CfgIdxW-1:0] REG_DEFROST_END       = 4'd7;

    // Register reset values
    localparam logic [TempW-1:0] RST_WATER_TARGET     = 12'd720;
    localparam logic [HysW-1:0]  RST_HYSTERESIS       = 10'd32;
    localparam logic [TempW-1:0] RST_SUMP_HEATER_TEMP = 12'd80;
    localparam logic [TimeW-1:0] RST_RUN_TIMEOUT_MS   = 32'd600000;
    localparam logic [TempW-1:0] RST_DEFROST_START    = 12'hFE0;
    localparam logic [TempW-1:0] RST_FAN_TARGET       = 12'd160;
    localparam logic [TempW-1:0] RST_HEATED_MARK      = 12'd480;
    localparam logic [TempW-1:0] RST_DEFROST_END      = 12'd160;

    typedef struct packed {
        logic [TempW-1:0] water_target;
        logic [HysW-1:0]  hysteresis;
        logic [TempW-1:0] sump_heater_temp;
        logic [TimeW-1:0] run_timeout_ms;
        logic [TempW-1:0] defrost_start_temp;
        logic [TempW-1:0] fan_target_temp;
        logic [TempW-1:0] heated_mark_temp;
        logic [TempW-1:0] defrost_end_temp;
    } cfg_t;

    typedef struct packed {
        logic [TempW-1:0] water_out_temp;
        logic [TempW-1:0] coolant_out_temp;
        logic [TempW-1:0] coolant_in_temp;
        logic [TempW-1:0] outside_air_temp;
        logic [TimeW-1:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic             compressor_run;
        logic             fan_run;
        logic             defrost_run;
        logic             sump_run;
        logic             pump_run;
        logic [TimeW-1:0] fan_start_stamp;
        logic [TimeW-1:0] defrost_start_stamp;
        logic             heated_flag;
        logic             fault_latch;
        logic             mode_defrost;
        logic             sign_flag;
    } state_t;

    // Sign-extend a temperature by one bit so thresholds with hysteresis fit
    function automatic logic signed [ThrW-1:0] sx_temp(input logic [TempW-1:0] v);
        return {v[TempW-1], v};
    endfunction

endpackage

@@ src/heat_pump_sequencer.sv @@
// ----------------------------------------------------------------------------
// heat_pump_sequencer
// A sample goes through the sample register, then the state/result register,
// waiting in the first while the output side is busy. Throughput: one sample
// per cycle while out_ready is high, with a single rule pass between the two.
// Reset: asynchronous, clears all drives, flags, stamps and both valid bits and
// loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
module heat_pump_sequencer
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hps_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [hps_pkg::CfgDatW-1:0]    cfg_data,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [hps_pkg::TempW-1:0]      water_out_temp,
    input  logic [hps_pkg::TempW-1:0]      coolant_out_temp,
    input  logic [hps_pkg::TempW-1:0]      coolant_in_temp,
    input  logic [hps_pkg::TempW-1:0]      outside_air_temp,
    input  logic [hps_pkg::TimeW-1:0]      now_ms,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           compressor_on,
    output logic                           fan_on,
    output logic                           defrost_valve_on,
    output logic                           sump_heater_on,
    output logic                           pump_on,
    output logic                           fault,
    output logic                           heated_once,
    output logic                           defrost_mode,
    output logic                           attention_sign
);

    hps_pkg::cfg_t    cfg;
    hps_pkg::sample_t smp_reg;
    hps_pkg::state_t  state_reg;
    hps_pkg::state_t  state_next;
    logic             smp_valid_reg;
    logic             out_valid_reg;
    logic             advance;

    assign cfg_ready = 1'b1;

    hps_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hps_rules u_rules
    (
        .cfg (cfg),
        .smp (smp_reg),
        .cur (state_reg),
        .nxt (state_next)
    );

    // move the held sample into the state when the result slot is free
    assign advance  = smp_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !smp_valid_reg || advance;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            smp_reg.water_out_temp   <= water_out_temp;
            smp_reg.coolant_out_temp <= coolant_out_temp;
            smp_reg.coolant_in_temp  <= coolant_in_temp;
            smp_reg.outside_air_temp <= outside_air_temp;
            smp_reg.now_ms           <= now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                smp_valid_reg <= 1'b1;
            else if (advance)
                smp_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign compressor_on    = state_reg.compressor_run;
    assign fan_on           = state_reg.fan_run;
    assign defrost_valve_on = state_reg.defrost_run;
    assign sump_heater_on   = state_reg.sump_run;
    assign pump_on          = state_reg.pump_run;
    assign fault            = state_reg.fault_latch;
    assign heated_once      = state_reg.heated_flag;
    assign defrost_mode     = state_reg.mode_defrost;
    assign attention_sign   = state_reg.sign_flag;

    // fault holds the compressor, pump and sump heater off
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.fault_latch |-> !state_reg.compressor_run && !state_reg.pump_run
                                  && !state_reg.sump_run)
        else $error("drive on while fault latched");

    // only reset clears the fault
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.fault_latch |=> state_reg.fault_latch)
        else $error("fault latch cleared");

    // defrost mode is entered only after the heated mark and left with it
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.mode_defrost |-> state_reg.heated_flag)
        else $error("defrost mode without heated flag");

    // state changes only when a sample moves through
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without a transaction");

endmodule

@@ src/hps_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// hps_cfg_regs
// Configuration register file; writes to an index beyond the list are dropped.
// ----------------------------------------------------------------------------
module hps_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [hps_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [hps_pkg::CfgDatW-1:0]   cfg_data,
    output hps_pkg::cfg_t                 cfg
);

    hps_pkg::cfg_t cfg_reg;
    hps_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                hps_pkg::REG_WATER_TARGET:
                    cfg_next.water_target = cfg_data[hps_pkg::TempW-1:0];
                hps_pkg::REG_HYSTERESIS:
                    cfg_next.hysteresis = cfg_data[hps_pkg::HysW-1:0];
                hps_pkg::REG_SUMP_HEATER_TEMP:
                    cfg_next.sump_heater_temp = cfg_data[hps_pkg::TempW-1:0];
                hps_pkg::REG_RUN_TIMEOUT_MS:
                    cfg_next.run_timeout_ms = cfg_data[hps_pkg::TimeW-1:0];
                hps_pkg::REG_DEFROST_START:
                    cfg_next.defrost_start_temp = cfg_data[hps_pkg::TempW-1:0];
                hps_pkg::REG_FAN_TARGET:
                    cfg_next.fan_target_temp = cfg_data[hps_pkg::TempW-1:0];
                hps_pkg::REG_HEATED_MARK:
                    cfg_next.heated_mark_temp = cfg_data[hps_pkg::TempW-1:0];
                hps_pkg::REG_DEFROST_END:
                    cfg_next.defrost_end_temp = cfg_data[hps_pkg::TempW-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.water_target       <= hps_pkg::RST_WATER_TARGET;
            cfg_reg.hysteresis         <= hps_pkg::RST_HYSTERESIS;
            cfg_reg.sump_heater_temp   <= hps_pkg::RST_SUMP_HEATER_TEMP;
            cfg_reg.run_timeout_ms     <= hps_pkg::RST_RUN_TIMEOUT_MS;
            cfg_reg.defrost_start_temp <= hps_pkg::RST_DEFROST_START;
            cfg_reg.fan_target_temp    <= hps_pkg::RST_FAN_TARGET;
            cfg_reg.heated_mark_temp   <= hps_pkg::RST_HEATED_MARK;
            cfg_reg.defrost_end_temp   <= hps_pkg::RST_DEFROST_END;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/hps_rules.sv @@
// ----------------------------------------------------------------------------
// hps_rules
// One pass of the control rules: current state and a sample in, next state out.
// ----------------------------------------------------------------------------
module hps_rules
(
    input  hps_pkg::cfg_t     cfg,
    input  hps_pkg::sample_t  smp,
    input  hps_pkg::state_t   cur,
    output hps_pkg::state_t   nxt
);

    logic signed [hps_pkg::ThrW-1:0] w_out;
    logic signed [hps_pkg::ThrW-1:0] c_out;
    logic signed [hps_pkg::ThrW-1:0] c_in;
    logic signed [hps_pkg::ThrW-1:0] air;
    logic signed [hps_pkg::ThrW-1:0] tgt;
    logic signed [hps_pkg::ThrW-1:0] hys;
    logic signed [hps_pkg::ThrW-1:0] sump_t;
    logic signed [hps_pkg::ThrW-1:0] fan_t;
    logic signed [hps_pkg::ThrW-1:0] mark_t;
    logic signed [hps_pkg::ThrW-1:0] dstart_t;
    logic signed [hps_pkg::ThrW-1:0] dend_t;
    logic [hps_pkg::TimeW-1:0]       now;
    logic [hps_pkg::TimeW-1:0]       fan_elapsed;
    logic [hps_pkg::TimeW-1:0]       def_elapsed;
    hps_pkg::state_t                 s;

    assign w_out    = hps_pkg::sx_temp(smp.water_out_temp);
    assign c_out    = hps_pkg::sx_temp(smp.coolant_out_temp);
    assign c_in     = hps_pkg::sx_temp(smp.coolant_in_temp);
    assign air      = hps_pkg::sx_temp(smp.outside_air_temp);
    assign now      = smp.now_ms;
    assign tgt      = hps_pkg::sx_temp(cfg.water_target);
    assign hys      = $signed({{(hps_pkg::ThrW-hps_pkg::HysW){1'b0}}, cfg.hysteresis});
    assign sump_t   = hps_pkg::sx_temp(cfg.sump_heater_temp);
    assign fan_t    = hps_pkg::sx_temp(cfg.fan_target_temp);
    assign mark_t   = hps_pkg::sx_temp(cfg.heated_mark_temp);
    assign dstart_t = hps_pkg::sx_temp(cfg.defrost_start_temp);
    assign dend_t   = hps_pkg::sx_temp(cfg.defrost_end_temp);

    always_comb
    begin
        s           = cur;
        fan_elapsed = now - cur.fan_start_stamp;
        def_elapsed = '0;

        if (cur.fault_latch)
        begin
            s.compressor_run = 1'b0;
            s.fan_run        = 1'b0;
            s.pump_run       = 1'b0;
            s.sump_run       = 1'b0;
            s.defrost_run    = 1'b0;
        end
        else if (w_out >= tgt)
        begin
            // water at target: everything but the defrost valve stops
            s.compressor_run = 1'b0;
            s.fan_run        = 1'b0;
            s.pump_run       = 1'b0;
            s.sump_run       = 1'b0;
        end
        else
        begin
            if (air <= sump_t)
                s.sump_run = 1'b0 | 1'b1;
            if (air >= sump_t + hys)
                s.sump_run = 1'b0;

            // water is below target here, so the compressor runs unless a timeout below
            // latches the fault, and the heated overshoot stop cannot fire
            s.compressor_run = 1'b1;

            if (s.fan_run && (fan_elapsed >= cfg.run_timeout_ms))
            begin
                if (s.heated_flag)
                begin
                    s.compressor_run = 1'b0;
                    s.fan_run        = 1'b0;
                    s.pump_run       = 1'b0;
                    s.sump_run       = 1'b0;
                    s.fault_latch    = 1'b1;
                end
                else
                begin
                    // forced defrost: open the valve, leave the mode alone
                    s.heated_flag = 1'b1;
                    if (!s.defrost_run)
                    begin
                        s.defrost_run         = 1'b1;
                        s.defrost_start_stamp = now;
                    end
                    s.fan_start_stamp = now;
                    s.sign_flag       = 1'b1;
                end
            end

            if (s.compressor_run)
            begin
                if (c_out >= tgt)
                    s.pump_run = 1'b1;
                if (s.heated_flag && (c_out <= tgt - hys))
                    s.pump_run = 1'b0;

                if (c_out >= mark_t)
                    s.heated_flag = 1'b1;
                if (c_out >= fan_t)
                begin
                    s.sign_flag = 1'b0;
                    s.fan_run   = 1'b0;
                end
                if ((c_out <= fan_t - hys) && !s.fan_run && !s.defrost_run)
                begin
                    s.fan_run         = 1'b1;
                    s.fan_start_stamp = now;
                end
            end

            if (s.compressor_run && s.heated_flag && !s.defrost_run && (c_out <= dstart_t))
            begin
                s.fan_run             = 1'b0;
                s.defrost_run         = 1'b1;
                s.defrost_start_stamp = now;
                s.mode_defrost        = 1'b1;
            end

            if (s.defrost_run && (c_in >= dend_t))
            begin
                s.defrost_run = 1'b0;
                if (!s.fan_run)
                begin
                    s.fan_run         = 1'b1;
                    s.fan_start_stamp = now;
                end
                s.heated_flag  = 1'b0;
                s.mode_defrost = 1'b0;
            end

            def_elapsed = now - s.defrost_start_stamp;
            if (s.defrost_run && (def_elapsed >= cfg.run_timeout_ms))
            begin
                s.compressor_run = 1'b0;
                s.fan_run        = 1'b0;
                s.pump_run       = 1'b0;
                s.sump_run       = 1'b0;
                s.fault_latch    = 1'b1;
            end
        end
    end

    assign nxt = s;

endmodule
